>>> rtl/core/buddy_block_allocator_defines.svh
// Assertion macros shared by the allocator RTL
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BBA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BBA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;
    localparam int MAX_ORDER  = 12;
    localparam int MIN_ORDER  = 4;
    localparam int LEVELS     = MAX_ORDER - MIN_ORDER;
    localparam int SLOT_COUNT = 1 << LEVELS;
    localparam int SLOT_W     = LEVELS;
    localparam int OFF_W      = 12;
    localparam int ORD_W      = 4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;
    localparam logic ST_DONE   = 1'b0;
    localparam logic ST_NOSPC  = 1'b1;

    typedef struct packed {
        logic             command;
        logic [OFF_W-1:0] request_size;
        logic [OFF_W-1:0] block_offset;
    } bba_in_t;

    typedef struct packed {
        logic             status;
        logic [OFF_W-1:0] granted_offset;
        logic [ORD_W-1:0] block_order;
    } bba_out_t;

    typedef enum logic [3:0] {
        S_IDLE, S_A_SEARCH, S_A_SPLIT, S_A_DONE, S_NOSPC,
        S_F_READ, S_F_ORD, S_F_MERGE, S_F_DONE, S_OUT
    } bba_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word
        logic a_init;     // compute needed order
        logic a_step;     // search one level
        logic a_split;    // split one level
        logic a_commit;   // write order table
        logic f_ord;      // take order from table
        logic f_step;     // one merge step
        logic f_commit;   // set final free bit
        logic set_nospc;
        logic set_done;
    } bba_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic too_big;
        logic found;
        logic search_end;
        logic split_end;
        logic merge_end;
    } bba_stat_t;
endpackage

>>> rtl/core/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate and free operations.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_defines.svh"
module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_cmd,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd
);
    import bba_pkg::*;

    bba_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = (in_cmd == CMD_FREE) ? S_F_READ : S_A_SEARCH;
            S_A_SEARCH:
            begin
                if (stat.too_big)         state_next = S_NOSPC;
                else if (stat.found)      state_next = S_A_SPLIT;
                else if (stat.search_end) state_next = S_NOSPC;
            end
            S_A_SPLIT:  if (stat.split_end) state_next = S_A_DONE;
            S_A_DONE:   state_next = S_OUT;
            S_NOSPC:    state_next = S_OUT;
            S_F_READ:   state_next = S_F_ORD;
            S_F_ORD:    state_next = S_F_MERGE;
            S_F_MERGE:  if (stat.merge_end) state_next = S_F_DONE;
            S_F_DONE:   state_next = S_OUT;
            S_OUT:      if (out_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.load   = in_valid;
                cmd.a_init = in_valid;
            end
            S_A_SEARCH: cmd.a_step   = !stat.too_big;
            S_A_SPLIT:  cmd.a_split  = !stat.split_end;
            S_A_DONE:
            begin
                cmd.a_commit = 1'b1;
                cmd.set_done = 1'b1;
            end
            S_NOSPC:    cmd.set_nospc = 1'b1;
            S_F_READ:   ;
            S_F_ORD:    cmd.f_ord    = 1'b1;
            S_F_MERGE:  cmd.f_step   = 1'b1;
            S_F_DONE:
            begin
                cmd.f_commit = 1'b1;
                cmd.set_done = 1'b1;
            end
            S_OUT:      out_valid = 1'b1;
            default:    ;
        endcase
    end

    `BBA_ASSERT_IMP(a_rdy_excl, in_ready, !out_valid, "ready while result pending")
    `BBA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
    `BBA_ASSERT_IMP(a_cmd_one, 1'b1, $onehot0({cmd.a_commit, cmd.f_commit, cmd.set_nospc}),
        "conflicting commits")
endmodule

>>> rtl/core/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Free bitmap, order table and level arithmetic.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_defines.svh"
module bba_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  bba_pkg::bba_in_t   in_word,
    input  bba_pkg::bba_cmd_t  cmd,
    output bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_out_t  out_word
);
    import bba_pkg::*;

    localparam int LW = $clog2(MAX_ORDER + 2);

    // one bit-row per order level; level MIN_ORDER holds SLOT_COUNT bits
    logic [SLOT_COUNT-1:0] map_reg [MIN_ORDER:MAX_ORDER];
    logic [ORD_W-1:0]      otab [SLOT_COUNT];
    logic [ORD_W-1:0]      otab_rd_reg;

    bba_in_t          in_reg;
    logic [LW-1:0]    need_reg, lvl_reg;
    logic [OFF_W-1:0] off_reg;
    bba_out_t         res_reg;

    // size+1 needs order >= ceil(log2(size+1)) = bit length of size
    logic [LW-1:0] need_c;
    always_comb
    begin
        need_c = '0;
        for (int b = 0; b < OFF_W; b++)
            if (in_word.request_size[b]) need_c = LW'(b + 1);
        if (need_c < LW'(MIN_ORDER)) need_c = LW'(MIN_ORDER);
    end

    // lowest free block in the current level
    logic [SLOT_COUNT-1:0] row;
    logic                  row_any;
    logic [SLOT_W-1:0]     row_idx;
    always_comb
    begin
        row     = map_reg[lvl_reg[ORD_W-1:0]];
        row_any = 1'b0;
        row_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
            if (row[i]) begin row_any = 1'b1; row_idx = SLOT_W'(i); end
    end

    // index of an offset at a level
    function automatic logic [SLOT_W-1:0] bidx(input logic [OFF_W-1:0] o,
                                               input logic [LW-1:0] l);
        bidx = SLOT_W'(o >> l);
    endfunction

    logic [OFF_W-1:0] buddy_c;
    logic             buddy_free;
    assign buddy_c    = off_reg ^ (OFF_W'(1) << lvl_reg);
    assign buddy_free = (lvl_reg < LW'(MAX_ORDER)) &&
                        map_reg[lvl_reg[ORD_W-1:0]][bidx(buddy_c, lvl_reg)];

    assign stat.too_big    = need_reg > LW'(MAX_ORDER);
    assign stat.found      = row_any;
    assign stat.search_end = lvl_reg >= LW'(MAX_ORDER);
    assign stat.split_end  = lvl_reg == need_reg;
    assign stat.merge_end  = !buddy_free;

    logic [LW-1:0] ford;
    always_comb
    begin
        ford = LW'(otab_rd_reg);
        if (ford < LW'(MIN_ORDER)) ford = LW'(MIN_ORDER);
        if (ford > LW'(MAX_ORDER)) ford = LW'(MAX_ORDER);
    end

    always_ff @(posedge clk)
    begin
        otab_rd_reg <= otab[in_reg.block_offset[OFF_W-1:MIN_ORDER]];
        if (cmd.a_commit)
            otab[off_reg[OFF_W-1:MIN_ORDER]] <= ORD_W'(need_reg);
    end

    logic [LW-1:0] lm1;
    assign lm1 = lvl_reg - LW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = MIN_ORDER; l < MAX_ORDER; l++)
                map_reg[l] <= '0;
            map_reg[MAX_ORDER] <= SLOT_COUNT'(1);
        end
        else
        begin
            if (cmd.a_step && row_any)
                map_reg[lvl_reg[ORD_W-1:0]][row_idx] <= 1'b0;
            if (cmd.a_split)
                map_reg[lm1[ORD_W-1:0]][bidx(off_reg + (OFF_W'(1) << lm1), lm1)] <= 1'b1;
            if (cmd.f_step && buddy_free)
                map_reg[lvl_reg[ORD_W-1:0]][bidx(buddy_c, lvl_reg)] <= 1'b0;
            if (cmd.f_commit)
                map_reg[lvl_reg[ORD_W-1:0]][bidx(off_reg, lvl_reg)] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) in_reg <= in_word;
        if (cmd.a_init)
        begin
            need_reg <= need_c;
            lvl_reg  <= need_c;
        end
        if (cmd.a_step)
        begin
            if (row_any) off_reg <= OFF_W'({row_idx, {MIN_ORDER{1'b0}}} << (lvl_reg - LW'(MIN_ORDER)));
            else         lvl_reg <= lvl_reg + LW'(1);
        end
        if (cmd.a_split) lvl_reg <= lm1;
        if (cmd.f_ord)
        begin
            lvl_reg <= ford;
            off_reg <= in_reg.block_offset & ~((OFF_W'(1) << ford) - OFF_W'(1));
        end
        if (cmd.f_step && buddy_free)
        begin
            lvl_reg <= lvl_reg + LW'(1);
            off_reg <= off_reg & buddy_c;
        end
        if (cmd.set_done)  res_reg <= '{ST_DONE, off_reg, ORD_W'(lvl_reg)};
        if (cmd.set_nospc) res_reg <= '{ST_NOSPC, '0, '0};
    end

    assign out_word = res_reg;

    `BBA_ASSERT_IMP(a_lvl_rng, cmd.a_split || cmd.f_step, lvl_reg <= LW'(MAX_ORDER),
        "level out of range")
    `BBA_ASSERT_IMP(a_off_align, cmd.f_commit,
        (off_reg & ((OFF_W'(1) << lvl_reg) - OFF_W'(1))) == '0, "unaligned merged block")
    `BBA_ASSERT_IMP(a_split_ok, cmd.a_commit, lvl_reg == need_reg, "split incomplete")
endmodule

>>> rtl/core/buddy_block_allocator.sv
// Sequence: allocate searches levels upward, then splits levels down; free reads the
// order table, then takes merge steps upward.
// Throughput: one word in flight, with a return to idle before the next is accepted;
// the walk over the free bitmap goes one level a cycle. Result held until taken.
// Reset: free map shows only the whole pool free; order table is not cleared.
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator top level.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bba_pkg::bba_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bba_pkg::bba_out_t out_data
);
    import bba_pkg::*;

    bba_cmd_t  cmd;
    bba_stat_t stat;

    bba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_data.command),
        .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .cmd(cmd)
    );

    bba_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_data), .cmd(cmd),
        .stat(stat), .out_word(out_data)
    );
endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free words through the valid/ready input channel and
// compares each result word against a bitmap model of the buddy heap.
// Directed corner words come first, then random alloc/free traffic.
// ----------------------------------------------------------------------------
class buddy_scoreboard;
    bit          free_bits[511];
    logic [3:0]  order_of_slot[256];
    bba_pkg::bba_out_t pending[$];
    int          mismatches;

    function new();
        foreach (free_bits[i]) free_bits[i] = 0;
        free_bits[0] = 1;
        mismatches = 0;
    endfunction

    function int heap_idx(int ord, int off);
        return ((1 << (12 - ord)) - 1) + (off >> ord);
    endfunction

    // predict the result of one accepted word and update the heap copy
    function bba_pkg::bba_out_t note_word(bba_pkg::bba_in_t w);
        bba_pkg::bba_out_t r;
        int need, lvl, off, ord, buddy, bi;
        bit found;
        r = '0;
        found = 0;
        off = 0;
        if (w.command == bba_pkg::CMD_ALLOC) begin
            need = 0;
            while (need < 13 && (1 << need) < int'(w.request_size) + 1) need++;
            if (need < bba_pkg::MIN_ORDER) need = bba_pkg::MIN_ORDER;
            if (need <= bba_pkg::MAX_ORDER) begin
                for (lvl = need; lvl <= 12 && !found; lvl++) begin
                    for (int b = 0; b < (1 << (12 - lvl)); b++) begin
                        if (free_bits[heap_idx(lvl, b << lvl)]) begin
                            free_bits[heap_idx(lvl, b << lvl)] = 0;
                            off = b << lvl;
                            found = 1;
                            break;
                        end
                    end
                    if (found) break;
                end
            end
            if (!found) begin
                r.status = bba_pkg::ST_NOSPC;
            end else begin
                while (lvl > need) begin
                    lvl--;
                    free_bits[heap_idx(lvl, off + (1 << lvl))] = 1;
                end
                order_of_slot[off >> 4] = need[3:0];
                r.status = bba_pkg::ST_DONE;
                r.granted_offset = off[11:0];
                r.block_order = need[3:0];
            end
        end else begin
            off = w.block_offset;
            ord = order_of_slot[off >> 4];
            if (ord < 4) ord = 4;
            if (ord > 12) ord = 12;
            off = off & ~((1 << ord) - 1);
            while (ord < 12) begin
                buddy = off ^ (1 << ord);
                bi = heap_idx(ord, buddy);
                if (!free_bits[bi]) break;
                free_bits[bi] = 0;
                if (buddy < off) off = buddy;
                ord++;
            end
            free_bits[heap_idx(ord, off)] = 1;
            r.status = bba_pkg::ST_DONE;
            r.granted_offset = off[11:0];
            r.block_order = ord[3:0];
        end
        pending.push_back(r);
        return r;
    endfunction

    function void check_word(bba_pkg::bba_out_t got);
        bba_pkg::bba_out_t exp_w;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
        end
        exp_w = pending.pop_front();
        if (got.status !== exp_w.status || got.granted_offset !== exp_w.granted_offset
            || got.block_order !== exp_w.block_order) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp st=%0d off=%0d ord=%0d got st=%0d off=%0d ord=%0d",
                         exp_w.status, exp_w.granted_offset, exp_w.block_order,
                         got.status, got.granted_offset, got.block_order);
        end
    endfunction
endclass

module testbench;
    import bba_pkg::*;

    logic     clk = 0;
    logic     rst_n = 0;
    logic     in_valid = 0;
    logic     in_ready;
    bba_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 0;
    bba_out_t out_data;

    buddy_scoreboard sb = new();
    int send_idle_pct = 24;
    int recv_idle_pct = 61;
    int live_offsets[$];
    bit written_slot[256];

    buddy_block_allocator dut (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    initial
    begin
        #5000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_word(out_data);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid drops only when the sender idles, so back-to-back words stay high
    task send_word(input bba_in_t w);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        void'(sb.note_word(w));
        // track grants so frees target written slots
        if (w.command == CMD_ALLOC && sb.pending[$].status == ST_DONE) begin
            live_offsets.push_back(sb.pending[$].granted_offset);
            written_slot[sb.pending[$].granted_offset >> 4] = 1;
        end
    endtask

    task do_alloc(input int size);
        bba_in_t w;
        w.command = CMD_ALLOC;
        w.request_size = size[11:0];
        w.block_offset = 12'($urandom);
        send_word(w);
    endtask

    // free a live block, offset perturbed within its slot; a noisy free keeps it listed
    task do_free(input bit noisy);
        bba_in_t w;
        int k, off;
        if (live_offsets.size() == 0) return;
        k = $urandom_range(live_offsets.size() - 1);
        off = live_offsets[k];
        if (!noisy || !written_slot[off >> 4]) live_offsets.delete(k);
        w.command = CMD_FREE;
        w.request_size = 12'($urandom);
        // low nibble is misalignment within slot
        w.block_offset = off[11:0] | 12'($urandom_range(15));
        if (noisy) w.block_offset = off[11:0] | 12'($urandom_range(15));
        send_word(w);
    endtask

    task random_phase(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                if ($urandom_range(9) == 0) do_alloc($urandom_range(4095));
                else do_alloc($urandom_range(1 << $urandom_range(4, 10)));
            end else if (r < 95) begin
                do_free(0);
            end else begin
                do_free(1);
            end
        end
    endtask

    initial
    begin
        int wait_cycles;
        bba_in_t w;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed corners
        do_alloc(4095);
        do_alloc(0);
        do_alloc(15);
        do_alloc(16);
        do_alloc(2047);
        do_alloc(4094);
        do_alloc(4095);
        do_alloc(1023);
        do_alloc(255);
        // free with wrapped offset: same slot plus pool size bit is not present
        // in 12 bits, so use misaligned low bits instead
        while (live_offsets.size() > 0) do_free(0);
        do_alloc(4094);
        // misaligned alias of offset 0 inside the full-pool block
        w.command = CMD_FREE;
        w.request_size = 12'hfff;
        w.block_offset = 12'h00f;
        live_offsets.delete();
        send_word(w);
        // double free of the pool block
        w.block_offset = 12'h0;
        send_word(w);
        do_alloc(4094);
        do_alloc(0);
        w.block_offset = 12'h0;
        send_word(w);
        live_offsets.delete();
        random_phase(200);
        send_idle_pct = 61;
        recv_idle_pct = 24;
        random_phase(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(200);
        in_valid <= 0;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 100000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
